FILE: rtl/bsf_pkg.sv
// Shared types, constants and functions of the byte-stuffing CRC-8 framer.
// Used by bsf_front, bsf_fifo, bsf_back and byte_stuffing_crc8_framer_unit.
// Depends on nothing else.
package bsf_pkg;

    // Widths of the byte path and of the configuration index.
    localparam int DataW     = 8;
    localparam int CfgIdxW   = 3;

    // One input item expands into at most five output bytes.
    localparam int MaxBytes  = 5;
    localparam int CntW      = $clog2(MaxBytes + 1);

    // Command queue between the front and back parts.
    localparam int FifoDepth = 4;
    localparam int FifoAw    = $clog2(FifoDepth);

    // Reset values of the configuration registers.
    localparam logic [DataW-1:0] StartReset     = 8'd126;
    localparam logic [DataW-1:0] EscapeReset    = 8'd125;
    localparam logic [DataW-1:0] StartCodeReset = 8'd94;
    localparam logic [DataW-1:0] EscCodeReset   = 8'd93;
    localparam logic [DataW-1:0] PolyReset      = 8'd213;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_START      = 3'd0,
        REG_ESCAPE     = 3'd1,
        REG_START_CODE = 3'd2,
        REG_ESC_CODE   = 3'd3,
        REG_POLY       = 3'd4
    } cfg_reg_t;

    // Current configuration as seen by the front part.
    typedef struct packed {
        logic [DataW-1:0] start_byte;
        logic [DataW-1:0] escape_byte;
        logic [DataW-1:0] start_code;
        logic [DataW-1:0] escape_code;
        logic [DataW-1:0] poly;
    } cfg_t;

    // One queued command: the finished output bytes of one input item.
    typedef struct packed {
        logic [MaxBytes-1:0][DataW-1:0] bytes;
        logic [CntW-1:0]                count;
        logic                           frame_end;
    } item_t;

    // Result of escaping one byte: one or two output bytes.
    typedef struct packed {
        logic [1:0][DataW-1:0] bytes;
        logic                  two;
    } esc_t;

    // Bitwise MSB-first CRC-8 over one byte, no final xor.
    function automatic logic [DataW-1:0] crc8_fold(input logic [DataW-1:0] crc,
                                                   input logic [DataW-1:0] b,
                                                   input logic [DataW-1:0] poly);
        logic [DataW-1:0] v;
        v = crc ^ b;
        for (int k = 0; k < DataW; k++) begin
            if (v[DataW-1]) begin
                v = {v[DataW-2:0], 1'b0} ^ poly;
            end else begin
                v = {v[DataW-2:0], 1'b0};
            end
        end
        return v;
    endfunction

    // Escape one byte; the start substitution wins when start equals escape.
    function automatic esc_t escape_byte_fn(input logic [DataW-1:0] b,
                                            input cfg_t cfg);
        esc_t e;
        if (b == cfg.start_byte) begin
            e.bytes[0] = cfg.escape_byte;
            e.bytes[1] = cfg.start_code;
            e.two      = 1'b1;
        end else if (b == cfg.escape_byte) begin
            e.bytes[0] = cfg.escape_byte;
            e.bytes[1] = cfg.escape_code;
            e.two      = 1'b1;
        end else begin
            e.bytes[0] = b;
            e.bytes[1] = '0;
            e.two      = 1'b0;
        end
        return e;
    endfunction

endpackage

FILE: rtl/bsf_front.sv
// Front part of the framer: accepts input transactions, runs the CRC and
// turns each item into a command of up to five finished output bytes.
// Depends on bsf_pkg.
module bsf_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bsf_pkg::cfg_t                cfg,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [bsf_pkg::DataW-1:0]    s_axis_tdata,  // [7:0] data_byte
    input  logic                         s_axis_tuser,  // [0] starts_message
    input  logic                         s_axis_tlast,  // ends_message
    input  logic                         fifo_full,
    output logic                         push,
    output bsf_pkg::item_t               push_item
);

    logic [bsf_pkg::DataW-1:0] crc_reg;
    logic [bsf_pkg::DataW-1:0] crc_next;
    logic [bsf_pkg::DataW-1:0] crc_seed;
    logic [bsf_pkg::DataW-1:0] crc_new;
    bsf_pkg::esc_t             data_esc;
    bsf_pkg::esc_t             crc_esc;
    logic [bsf_pkg::CntW-1:0]  pos;

    // Accept whenever the command queue has room.
    assign s_axis_tready = !fifo_full;
    assign push          = s_axis_tvalid && s_axis_tready;

    // Checksum of the message so far, including this byte.
    assign crc_seed = s_axis_tuser ? '0 : crc_reg;
    assign crc_new  = bsf_pkg::crc8_fold(crc_seed, s_axis_tdata, cfg.poly);
    assign data_esc = bsf_pkg::escape_byte_fn(s_axis_tdata, cfg);
    assign crc_esc  = bsf_pkg::escape_byte_fn(crc_new, cfg);

    // Lay out start byte, escaped data and escaped checksum in order.
    always_comb begin
        push_item = '0;
        pos       = '0;
        if (s_axis_tuser) begin
            push_item.bytes[0] = cfg.start_byte;
            pos                = bsf_pkg::CntW'(1);
        end
        push_item.bytes[pos] = data_esc.bytes[0];
        if (data_esc.two) begin
            push_item.bytes[pos + bsf_pkg::CntW'(1)] = data_esc.bytes[1];
            pos = pos + bsf_pkg::CntW'(2);
        end else begin
            pos = pos + bsf_pkg::CntW'(1);
        end
        if (s_axis_tlast) begin
            push_item.bytes[pos] = crc_esc.bytes[0];
            if (crc_esc.two) begin
                push_item.bytes[pos + bsf_pkg::CntW'(1)] = crc_esc.bytes[1];
                pos = pos + bsf_pkg::CntW'(2);
            end else begin
                pos = pos + bsf_pkg::CntW'(1);
            end
        end
        push_item.count     = pos;
        push_item.frame_end = s_axis_tlast;
    end

    // The checksum clears once it has been appended.
    always_comb begin
        crc_next = crc_reg;
        if (push) begin
            crc_next = s_axis_tlast ? '0 : crc_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else begin
            crc_reg <= crc_next;
        end
    end

    // A closed message leaves a zero checksum behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && s_axis_tlast |=> crc_reg == '0)
        else $error("bsf_front: checksum not cleared after end of message");

endmodule

FILE: rtl/bsf_fifo.sv
// Command queue between the front and back parts of the framer.
// Holds finished commands so that both sides can stall on their own.
// Depends on bsf_pkg.
module bsf_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bsf_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output bsf_pkg::item_t head,
    output logic           not_empty
);

    localparam logic [bsf_pkg::FifoAw:0] DepthVal = (bsf_pkg::FifoAw + 1)'(bsf_pkg::FifoDepth);

    bsf_pkg::item_t              mem [bsf_pkg::FifoDepth];
    logic [bsf_pkg::FifoAw-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bsf_pkg::FifoAw-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bsf_pkg::FifoAw:0]    count_reg, count_next;

    assign full      = count_reg == DepthVal;
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + bsf_pkg::FifoAw'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + bsf_pkg::FifoAw'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (bsf_pkg::FifoAw + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (bsf_pkg::FifoAw + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // The front never writes into a full queue, the back never reads an empty one.
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("bsf_fifo: write while full");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> not_empty)
        else $error("bsf_fifo: read while empty");

endmodule

FILE: rtl/bsf_back.sv
// Back part of the framer: walks the bytes of the head command, one byte per
// clock unless stalled, into a registered output stage. Depends on bsf_pkg.
module bsf_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bsf_pkg::item_t             head,
    input  logic                       head_valid,
    output logic                       pop,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [bsf_pkg::DataW-1:0]  m_axis_tdata,  // [7:0] out_byte
    output logic                       m_axis_tuser,  // [0] frame_done
    output logic                       m_axis_tlast   // last_of_run
);

    logic [bsf_pkg::CntW-1:0]  idx_reg, idx_next;
    logic                      valid_reg, valid_next;
    logic [bsf_pkg::DataW-1:0] data_reg, data_next;
    logic                      user_reg, user_next;
    logic                      last_reg, last_next;
    logic                      load;
    logic                      at_end;

    // Refill the output stage whenever it is empty or being taken.
    assign load   = head_valid && (!valid_reg || m_axis_tready);
    assign at_end = idx_reg == (head.count - bsf_pkg::CntW'(1));
    assign pop    = load && at_end;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = head.bytes[idx_reg];
            last_next  = at_end;
            user_next  = at_end && head.frame_end;
            idx_next   = at_end ? '0 : idx_reg + bsf_pkg::CntW'(1);
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

    // The byte index stays inside the head command and rests at zero when idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> idx_reg < head.count)
        else $error("bsf_back: byte index beyond command length");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> idx_reg == '0)
        else $error("bsf_back: byte index not reset with empty queue");

endmodule

FILE: rtl/byte_stuffing_crc8_framer_unit.sv
// Byte-stuffing framer with CRC-8: top level with the configuration registers.
// Instantiates bsf_front, bsf_fifo and bsf_back; depends on bsf_pkg.
//
// Each input transaction carries one message byte; tuser marks the message
// identifier and tlast the last byte. The block emits a start byte before the
// identifier, escapes start and escape bytes, and appends the escaped CRC-8
// after the last byte. One input transaction yields one to five output
// transactions; the output stage sends one byte per clock unless the output
// is stalled. A four-entry command queue lets the input side keep accepting
// one item per clock, as long as the queue has room, while earlier items are
// still being sent. Configuration is written through cfg_valid, cfg_index and
// cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce.
module byte_stuffing_crc8_framer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsf_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bsf_pkg::DataW-1:0]     cfg_data,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bsf_pkg::DataW-1:0]     s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tuser,  // [0] starts_message
    input  logic                          s_axis_tlast,  // ends_message
    // Output stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bsf_pkg::DataW-1:0]     m_axis_tdata,  // [7:0] out_byte
    output logic                          m_axis_tuser,  // [0] frame_done
    output logic                          m_axis_tlast   // last_of_run
);

    bsf_pkg::cfg_t  cfg_reg, cfg_next;
    bsf_pkg::item_t push_item;
    bsf_pkg::item_t head;
    logic           push;
    logic           fifo_full;
    logic           pop;
    logic           not_empty;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (bsf_pkg::cfg_reg_t'(cfg_index))
                bsf_pkg::REG_START:      cfg_next.start_byte  = cfg_data;
                bsf_pkg::REG_ESCAPE:     cfg_next.escape_byte = cfg_data;
                bsf_pkg::REG_START_CODE: cfg_next.start_code  = cfg_data;
                bsf_pkg::REG_ESC_CODE:   cfg_next.escape_code = cfg_data;
                bsf_pkg::REG_POLY:       cfg_next.poly        = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte  <= bsf_pkg::StartReset;
            cfg_reg.escape_byte <= bsf_pkg::EscapeReset;
            cfg_reg.start_code  <= bsf_pkg::StartCodeReset;
            cfg_reg.escape_code <= bsf_pkg::EscCodeReset;
            cfg_reg.poly        <= bsf_pkg::PolyReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and build commands.
    bsf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_item     (push_item)
    );

    // Command queue.
    bsf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    // Back: serialize bytes to the output stream.
    bsf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .head_valid    (not_empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: tb/byte_stuffing_crc8_framer_unit_tb.sv
// Self-checking testbench for the byte-stuffing CRC-8 framer.
// Frames are predicted per input byte and checked byte by byte on the output
// stream under several register settings and idle patterns; uses bsf_pkg.
`timescale 1ns / 100ps

module byte_stuffing_crc8_framer_unit_tb;

    localparam int CycleLimit = 100000;
    localparam int MaxReports = 100;

    // One message byte as it enters the block.
    typedef struct packed {
        logic [bsf_pkg::DataW-1:0] data;
        logic                      first;
        logic                      last;
    } msg_byte_t;

    // One byte of the framed output stream.
    typedef struct packed {
        logic [bsf_pkg::DataW-1:0] out_byte;
        logic                      last_of_run;
        logic                      frame_done;
    } framed_byte_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [bsf_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [bsf_pkg::DataW-1:0]    cfg_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [bsf_pkg::DataW-1:0]    s_axis_tdata = '0;  // [7:0] data_byte
    logic                         s_axis_tuser = 1'b0;  // [0] starts_message
    logic                         s_axis_tlast = 1'b0;  // ends_message
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [bsf_pkg::DataW-1:0]    m_axis_tdata;  // [7:0] out_byte
    logic                         m_axis_tuser;  // [0] frame_done
    logic                         m_axis_tlast;  // last_of_run

    // Stimulus queue, expected output bytes and bookkeeping.
    msg_byte_t    pending_bytes[$];
    framed_byte_t framed_expect[$];
    msg_byte_t    tx_item;
    int           queued_count = 0;
    int           accepted_count = 0;
    int           error_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;

    // Register copy used by the predictor and the one used to build traffic.
    bsf_pkg::cfg_t cur_cfg = {bsf_pkg::StartReset, bsf_pkg::EscapeReset,
                              bsf_pkg::StartCodeReset, bsf_pkg::EscCodeReset,
                              bsf_pkg::PolyReset};
    bsf_pkg::cfg_t gen_cfg = {bsf_pkg::StartReset, bsf_pkg::EscapeReset,
                              bsf_pkg::StartCodeReset, bsf_pkg::EscCodeReset,
                              bsf_pkg::PolyReset};
    logic [bsf_pkg::DataW-1:0] frame_crc = '0;

    byte_stuffing_crc8_framer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // MSB-first CRC-8 over one byte, implicit x^8 term, no final xor.
    function automatic logic [bsf_pkg::DataW-1:0] crc8_step(
        input logic [bsf_pkg::DataW-1:0] crc,
        input logic [bsf_pkg::DataW-1:0] b,
        input logic [bsf_pkg::DataW-1:0] poly);
        logic [bsf_pkg::DataW-1:0] v;
        v = crc ^ b;
        repeat (bsf_pkg::DataW) begin
            v = {v[bsf_pkg::DataW-2:0], 1'b0} ^ (v[bsf_pkg::DataW-1] ? poly : '0);
        end
        return v;
    endfunction

    // Escaped form of one byte under the predicted registers; returns 1 when
    // it takes two bytes. A start match wins over an escape match.
    function automatic logic escape_pair(input logic [bsf_pkg::DataW-1:0] b,
                                         output logic [bsf_pkg::DataW-1:0] lead,
                                         output logic [bsf_pkg::DataW-1:0] code);
        lead = b;
        code = '0;
        if (b == cur_cfg.start_byte) begin
            lead = cur_cfg.escape_byte;
            code = cur_cfg.start_code;
            return 1'b1;
        end else if (b == cur_cfg.escape_byte) begin
            lead = cur_cfg.escape_byte;
            code = cur_cfg.escape_code;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the output bytes that one accepted message byte causes.
    task automatic predict_run(input msg_byte_t m);
        logic [bsf_pkg::DataW-1:0] run_bytes[$];
        logic [bsf_pkg::DataW-1:0] lead;
        logic [bsf_pkg::DataW-1:0] code;
        framed_byte_t              f;
        if (m.first) begin
            run_bytes.push_back(cur_cfg.start_byte);
            frame_crc = '0;
        end
        frame_crc = crc8_step(frame_crc, m.data, cur_cfg.poly);
        if (escape_pair(m.data, lead, code)) begin
            run_bytes.push_back(lead);
            run_bytes.push_back(code);
        end else begin
            run_bytes.push_back(lead);
        end
        if (m.last) begin
            if (escape_pair(frame_crc, lead, code)) begin
                run_bytes.push_back(lead);
                run_bytes.push_back(code);
            end else begin
                run_bytes.push_back(lead);
            end
            frame_crc = '0;
        end
        for (int i = 0; i < run_bytes.size(); i++) begin
            f.out_byte    = run_bytes[i];
            f.last_of_run = (i == run_bytes.size() - 1);
            f.frame_done  = m.last && (i == run_bytes.size() - 1);
            framed_expect.push_back(f);
        end
    endtask

    task automatic report_field(input string name,
                                input logic [bsf_pkg::DataW-1:0] exp_v,
                                input logic [bsf_pkg::DataW-1:0] act_v);
        error_count++;
        if (error_count <= MaxReports) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h",
                     $time, name, exp_v, act_v);
        end
    endtask

    // Input driver: presents the next queued byte once the previous one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                tx_item = pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tx_item.data;
                s_axis_tuser  <= tx_item.first;
                s_axis_tlast  <= tx_item.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output backpressure.
    always @(posedge aclk) begin
        m_axis_tready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    // Monitor: tracks register writes, predicts each accepted input byte and
    // checks each output transaction against the oldest expected byte.
    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_crc = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (bsf_pkg::cfg_reg_t'(cfg_index))
                    bsf_pkg::REG_START:      cur_cfg.start_byte  = cfg_data;
                    bsf_pkg::REG_ESCAPE:     cur_cfg.escape_byte = cfg_data;
                    bsf_pkg::REG_START_CODE: cur_cfg.start_code  = cfg_data;
                    bsf_pkg::REG_ESC_CODE:   cur_cfg.escape_code = cfg_data;
                    bsf_pkg::REG_POLY:       cur_cfg.poly        = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_run({s_axis_tdata, s_axis_tuser, s_axis_tlast});
                accepted_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (framed_expect.size() == 0) begin
                    error_count++;
                    if (error_count <= MaxReports) begin
                        $display("%0t: output byte with nothing expected, %s %02h",
                                 $time, "expected none, actual", m_axis_tdata);
                    end
                end else begin
                    framed_byte_t e;
                    e = framed_expect.pop_front();
                    if (m_axis_tdata !== e.out_byte) begin
                        report_field("out_byte", e.out_byte, m_axis_tdata);
                    end
                    if (m_axis_tlast !== e.last_of_run) begin
                        report_field("last_of_run", e.last_of_run, m_axis_tlast);
                    end
                    if (m_axis_tuser !== e.frame_done) begin
                        report_field("frame_done", e.frame_done, m_axis_tuser);
                    end
                end
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("byte_stuffing_crc8_framer_unit_tb: errors");
            $finish;
        end
    end

    task automatic queue_item(input logic [bsf_pkg::DataW-1:0] data, input logic first,
                              input logic last);
        pending_bytes.push_back({data, first, last});
        queued_count++;
    endtask

    // Byte values biased toward the ones that trigger escaping.
    function automatic logic [bsf_pkg::DataW-1:0] pick_byte();
        case ($urandom_range(9))
            0: return gen_cfg.start_byte;
            1: return gen_cfg.escape_byte;
            2: return gen_cfg.start_code;
            3: return gen_cfg.escape_code;
            4: return 8'h00;
            5: return 8'hff;
            default: return bsf_pkg::DataW'($urandom);
        endcase
    endfunction

    // Payload byte that drives the running checksum to a chosen value.
    function automatic logic [bsf_pkg::DataW-1:0] byte_for_crc(
        input logic [bsf_pkg::DataW-1:0] crc,
        input logic [bsf_pkg::DataW-1:0] target,
        input logic [bsf_pkg::DataW-1:0] fallback);
        logic [bsf_pkg::DataW-1:0] b;
        b = fallback;
        for (int k = 0; k < 256; k++) begin
            if (crc8_step(crc, k[bsf_pkg::DataW-1:0], gen_cfg.poly) == target) begin
                b = k[bsf_pkg::DataW-1:0];
            end
        end
        return b;
    endfunction

    // Well-formed message; aim 1 or 2 steers the checksum onto the start or
    // the escape byte so that the appended checksum gets escaped.
    task automatic queue_message(input logic [bsf_pkg::DataW-1:0] id, input int len,
                                 input int aim);
        logic [bsf_pkg::DataW-1:0] crc;
        logic [bsf_pkg::DataW-1:0] b;
        crc = crc8_step('0, id, gen_cfg.poly);
        queue_item(id, 1'b1, len == 0);
        for (int i = 0; i < len; i++) begin
            b = pick_byte();
            if (i == len - 1 && aim != 0) begin
                b = byte_for_crc(crc, (aim == 1) ? gen_cfg.start_byte : gen_cfg.escape_byte, b);
            end
            crc = crc8_step(crc, b, gen_cfg.poly);
            queue_item(b, 1'b0, i == len - 1);
        end
    endtask

    // Mostly whole messages with random content, some stray bytes with random flags.
    task automatic queue_traffic(input int count);
        int made;
        int len;
        made = 0;
        while (made < count) begin
            if ($urandom_range(99) < 15) begin
                queue_item(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
                made++;
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(12, 6) : $urandom_range(4);
                queue_message(pick_byte(), len,
                              ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
                made += len + 1;
            end
        end
    endtask

    // Wait until every queued byte is taken and every expected byte has come out.
    task automatic wait_drained();
        do @(posedge aclk);
        while (accepted_count != queued_count || framed_expect.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input bsf_pkg::cfg_reg_t idx,
                             input logic [bsf_pkg::DataW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
    endtask

    task automatic program_regs(input bsf_pkg::cfg_t c);
        write_reg(bsf_pkg::REG_START, c.start_byte);
        write_reg(bsf_pkg::REG_ESCAPE, c.escape_byte);
        write_reg(bsf_pkg::REG_START_CODE, c.start_code);
        write_reg(bsf_pkg::REG_ESC_CODE, c.escape_code);
        write_reg(bsf_pkg::REG_POLY, c.poly);
        cfg_valid <= 1'b0;
        gen_cfg = c;
    endtask

    initial begin
        bsf_pkg::cfg_t c;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed part at the reset register values, no idling.
        // Stray payload bytes with no open message, plain and escaped.
        queue_item(8'h41, 1'b0, 1'b0);
        queue_item(bsf_pkg::StartReset, 1'b0, 1'b0);
        queue_item(bsf_pkg::EscapeReset, 1'b0, 1'b0);
        // Single-byte messages at both extremes.
        queue_item(8'h00, 1'b1, 1'b1);
        queue_item(8'hff, 1'b1, 1'b1);
        // Identifier equal to the start byte, payload hitting every special value.
        queue_item(bsf_pkg::StartReset, 1'b1, 1'b0);
        queue_item(bsf_pkg::EscapeReset, 1'b0, 1'b0);
        queue_item(bsf_pkg::StartCodeReset, 1'b0, 1'b0);
        queue_item(bsf_pkg::EscCodeReset, 1'b0, 1'b0);
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);
        // A new identifier while a message is still open.
        queue_item(8'h10, 1'b1, 1'b0);
        queue_item(8'h20, 1'b0, 1'b0);
        queue_item(8'h30, 1'b1, 1'b0);
        queue_item(8'h40, 1'b0, 1'b1);
        // An end marker with no start, then a stray byte after the end.
        queue_item(8'h55, 1'b0, 1'b1);
        queue_item(8'haa, 1'b0, 1'b0);
        // Checksums that land on the start and on the escape byte.
        queue_message(8'h12, 1, 1);
        queue_message(8'h34, 1, 2);
        // Single-byte message whose identifier is the escape byte.
        queue_item(bsf_pkg::EscapeReset, 1'b1, 1'b1);
        wait_drained();

        // All registers at zero: start equals escape, zero polynomial.
        c = '0;
        program_regs(c);
        send_idle_pct = 71;
        queue_traffic(25);
        wait_drained();

        // All registers at their maximum.
        c = '1;
        program_regs(c);
        send_idle_pct = 0;
        stall_pct = 71;
        queue_traffic(25);
        wait_drained();

        // Random distinct markers with an odd polynomial.
        c.start_byte = bsf_pkg::DataW'($urandom);
        do c.escape_byte = bsf_pkg::DataW'($urandom);
        while (c.escape_byte == c.start_byte);
        c.start_code  = bsf_pkg::DataW'($urandom);
        c.escape_code = bsf_pkg::DataW'($urandom);
        c.poly        = bsf_pkg::DataW'($urandom) | 8'h01;
        program_regs(c);
        send_idle_pct = 10;
        stall_pct = 10;
        queue_traffic(25);
        wait_drained();

        // Random shared start and escape value, then a run without idling.
        c.start_byte  = bsf_pkg::DataW'($urandom);
        c.escape_byte = c.start_byte;
        c.start_code  = bsf_pkg::DataW'($urandom);
        c.escape_code = bsf_pkg::DataW'($urandom);
        c.poly        = bsf_pkg::DataW'($urandom);
        program_regs(c);
        queue_traffic(12);
        wait_drained();
        send_idle_pct = 0;
        stall_pct = 0;
        queue_traffic(12);
        wait_drained();

        if (error_count == 0) begin
            $display("byte_stuffing_crc8_framer_unit_tb: clean");
        end else begin
            $display("byte_stuffing_crc8_framer_unit_tb: errors");
        end
        $finish;
    end

endmodule

FILE: byte_stuffing_crc8_framer_unit.f
rtl/bsf_pkg.sv
rtl/bsf_front.sv
rtl/bsf_fifo.sv
rtl/bsf_back.sv
rtl/byte_stuffing_crc8_framer_unit.sv
tb/byte_stuffing_crc8_framer_unit_tb.sv
